// ===== hdl/ppid_pkg.sv =====
// ----------------------------------------------------------------------------
// ppid_pkg - shared types and constants of the positional PID controller
// Fixed field widths, saturation points of the products, register indexes
// and the configuration bundle passed from the register bank to the datapath.
// ----------------------------------------------------------------------------
package ppid_pkg;

  // gains and integration rate, signed Q15.16
  localparam int GAIN_W     = 32;
  // multiplier digit taken per cycle by the serial multiplier
  localparam int DIG_W      = 8;
  // integral accumulator and clamp magnitudes
  localparam int ACC_W      = 40;
  localparam int LIMIT_W    = 15;
  localparam int DRIVE_W    = 16;
  // configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  // saturation points: integral step at 2^41, proportional and derivative terms at 2^61
  localparam int STEP_SAT_SH = 41;
  localparam int TERM_SAT_SH = 61;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_RATE  = 3'd3,
    REG_INTEG_LIMIT = 3'd4,
    REG_DRIVE_LIMIT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic signed [GAIN_W-1:0] integ_rate;
    logic [LIMIT_W-1:0]       integ_limit;
    logic [LIMIT_W-1:0]       drive_limit;
  } cfg_t;

endpackage

// ===== hdl/ppid_if.sv =====
// ----------------------------------------------------------------------------
// ppid_if - valid/ready channels of the positional PID controller
// Input request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// setpoint and measurement, one request per control step
interface ppid_in_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] target;
  logic signed [DATA_WIDTH-1:0] measured;

  modport source (output valid, target, measured, input ready);
  modport sink   (input valid, target, measured, output ready);
endinterface

// controller drive, one result per control step
interface ppid_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

// register write channel
interface ppid_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppid_pkg::CFG_IDX_W-1:0]  index;
  logic [ppid_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ppid_regs.sv =====
// ----------------------------------------------------------------------------
// ppid_regs - configuration register bank
// Decodes writes on the configuration channel into gains and clamp limits.
// Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ppid_regs (
  input  logic              clk,
  input  logic              rst_n,
  ppid_cfg_if.sink          cfg_ch,
  output ppid_pkg::cfg_t    cfg
);

  ppid_pkg::cfg_t cfg_r;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ppid_pkg::REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_ch.data;
        ppid_pkg::REG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_ch.data;
        ppid_pkg::REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_ch.data;
        ppid_pkg::REG_INTEG_RATE:  cfg_r.integ_rate  <= cfg_ch.data;
        ppid_pkg::REG_INTEG_LIMIT: cfg_r.integ_limit <= cfg_ch.data[ppid_pkg::LIMIT_W-1:0];
        ppid_pkg::REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_ch.data[ppid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/ppid_ser_mul.sv =====
// ----------------------------------------------------------------------------
// ppid_ser_mul - digit-serial unsigned multiplier
// The multiplier operand sits in the low end of a shift register and leaves
// it one digit per cycle; each cycle adds multiplicand times that digit to
// the running upper half and shifts the finished low digit in from the top.
// ----------------------------------------------------------------------------
module ppid_ser_mul #(
  parameter int MCAND_W = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [MCAND_W-1:0]                     mcand,
  input  logic [ppid_pkg::GAIN_W-1:0]            mplier,
  output logic                                   done,
  output logic [MCAND_W+ppid_pkg::GAIN_W-1:0]    prod
);

  localparam int PROD_W = MCAND_W + ppid_pkg::GAIN_W;
  localparam int PART_W = MCAND_W + ppid_pkg::DIG_W;
  localparam int DIGITS = ppid_pkg::GAIN_W / ppid_pkg::DIG_W;
  localparam int CNT_W  = $clog2(DIGITS + 1);

  logic [MCAND_W-1:0] mcand_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PART_W-1:0]  pp;
  logic [PART_W-1:0]  part;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  assign done = done_r;
  assign prod = prod_r;

  // one digit step: upper half plus multiplicand times the next digit
  always_comb begin
    pp       = PART_W'(mcand_r) * PART_W'(prod_r[ppid_pkg::DIG_W-1:0]);
    part     = PART_W'(prod_r[PROD_W-1:ppid_pkg::GAIN_W]) + pp;
    prod_nxt = {part, prod_r[ppid_pkg::GAIN_W-1:ppid_pkg::DIG_W]};
  end

  // digit counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIGITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      prod_r  <= {{MCAND_W{1'b0}}, mplier};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== hdl/positional_pid_controller.sv =====
// ----------------------------------------------------------------------------
// positional_pid_controller - positional PID with integral clamp
// One control step per request: error, clamped integral, error difference
// and a Q15.16 weighted sum, truncated toward zero and clamped to the drive
// limit.
// ----------------------------------------------------------------------------
// A request (target, measured) is accepted only while the controller is idle
// and gives one drive result; the next request can be taken only once that
// result is in the output register. Each step makes four passes through the one shared
// digit-serial multiplier (40 x 32 bits, 8 multiplier bits per cycle, each
// pass with operand load and capture) for the integral step, the
// proportional, derivative and integral terms, plus the integral clamp and
// the final sum, rounding and clamp in states of their own. A finished
// drive waits in an output register, so a stalled sink holds up only the next
// result. Register writes are taken every cycle and should be made while no
// request is in flight.
// ----------------------------------------------------------------------------
module positional_pid_controller #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ppid_in_if.sink     in_ch,
  ppid_out_if.source  out_ch,
  ppid_cfg_if.sink    cfg_ch
);

  localparam int GW     = ppid_pkg::GAIN_W;
  localparam int AW     = ppid_pkg::ACC_W;
  localparam int E_W    = DATA_WIDTH + 1;
  localparam int D_W    = DATA_WIDTH + 2;
  localparam int MCW    = (AW > D_W) ? AW : D_W;
  localparam int PW     = MCW + GW;
  localparam int INC_W  = ppid_pkg::STEP_SAT_SH + 2;
  localparam int TERM_W = ppid_pkg::TERM_SAT_SH + 2;
  localparam int AC_W   = TERM_W + 1;
  localparam int B_W    = PW + 1;
  localparam int SUM_W  = ((AW > INC_W) ? AW : INC_W) + 1;
  localparam int W_W    = (((AC_W + FRAC_BITS) > B_W) ? (AC_W + FRAC_BITS) : B_W) + 1;
  localparam int T_W    = W_W - 2 * FRAC_BITS + 1;
  localparam int DRW    = ppid_pkg::DRIVE_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_WAIT  = 7'b0000100,
    ST_ACC   = 7'b0001000,
    ST_SUM1  = 7'b0010000,
    ST_SUM2  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    OP_INC   = 2'd0,
    OP_PROP  = 2'd1,
    OP_DERIV = 2'd2,
    OP_INTEG = 2'd3
  } op_t;

  ppid_pkg::cfg_t cfg;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // step state and working registers
  logic signed [E_W-1:0]    prev_r;
  logic signed [E_W-1:0]    e_r;
  logic signed [D_W-1:0]    d_r;
  logic signed [AW-1:0]     acc_r;
  logic signed [INC_W-1:0]  inc_r;
  logic signed [TERM_W-1:0] a_r;
  logic signed [TERM_W-1:0] c_r;
  logic signed [B_W-1:0]    b_r;
  logic signed [AC_W-1:0]   ac_r;
  logic signed [W_W-1:0]    w_r;
  logic                     neg_r;
  logic                     out_valid_r;
  logic signed [DRW-1:0]    out_drive_r;

  logic                     in_take;
  logic                     out_load;
  logic signed [E_W-1:0]    e_nxt;
  logic signed [D_W-1:0]    d_nxt;

  logic [E_W-1:0]           e_mag;
  logic [D_W-1:0]           d_mag;
  logic [AW-1:0]            acc_mag;
  logic [GW-1:0]            rate_mag, pg_mag, dg_mag, ig_mag;
  logic [MCW-1:0]           mul_mcand;
  logic [GW-1:0]            mul_mplier;
  logic                     mul_neg;
  logic                     mul_start;
  logic                     mul_done;
  logic [PW-1:0]            mul_prod;

  logic [PW-1:0]            step_mag, term_mag;
  logic signed [INC_W-1:0]  inc_mag_s;
  logic signed [TERM_W-1:0] term_mag_s;
  logic signed [B_W-1:0]    b_mag_s;

  logic signed [SUM_W-1:0]  acc_sum, ilim;
  logic signed [AW-1:0]     acc_nxt;

  logic signed [T_W-1:0]    t_fl, t_val, lim;
  logic                     t_rnd;
  logic signed [DRW-1:0]    drive_nxt;

  ppid_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ppid_ser_mul #(
    .MCAND_W (MCW)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  // handshakes
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_take      = in_ch.valid && (state_r == ST_IDLE);
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = out_drive_r;
  assign mul_start    = (state_r == ST_START);

  // error and error difference at acceptance
  always_comb begin
    e_nxt = E_W'(in_ch.target) - E_W'(in_ch.measured);
    d_nxt = D_W'(e_nxt) - D_W'(prev_r);
  end

  // operand magnitudes and selection for the shared multiplier
  always_comb begin
    e_mag    = e_r[E_W-1] ? E_W'(-e_r) : E_W'(e_r);
    d_mag    = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
    acc_mag  = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
    rate_mag = cfg.integ_rate[GW-1] ? GW'(-cfg.integ_rate) : GW'(cfg.integ_rate);
    pg_mag   = cfg.prop_gain[GW-1]  ? GW'(-cfg.prop_gain)  : GW'(cfg.prop_gain);
    dg_mag   = cfg.deriv_gain[GW-1] ? GW'(-cfg.deriv_gain) : GW'(cfg.deriv_gain);
    ig_mag   = cfg.integ_gain[GW-1] ? GW'(-cfg.integ_gain) : GW'(cfg.integ_gain);
    unique case (op_r)
      OP_INC: begin
        mul_mcand  = MCW'(e_mag);
        mul_mplier = rate_mag;
        mul_neg    = e_r[E_W-1] ^ cfg.integ_rate[GW-1];
      end
      OP_PROP: begin
        mul_mcand  = MCW'(e_mag);
        mul_mplier = pg_mag;
        mul_neg    = e_r[E_W-1] ^ cfg.prop_gain[GW-1];
      end
      OP_DERIV: begin
        mul_mcand  = MCW'(d_mag);
        mul_mplier = dg_mag;
        mul_neg    = d_r[D_W-1] ^ cfg.deriv_gain[GW-1];
      end
      default: begin
        mul_mcand  = MCW'(acc_mag);
        mul_mplier = ig_mag;
        mul_neg    = acc_r[AW-1] ^ cfg.integ_gain[GW-1];
      end
    endcase
  end

  // product saturation and sign
  always_comb begin
    step_mag   = (mul_prod > (PW'(1) << ppid_pkg::STEP_SAT_SH)) ?
                 (PW'(1) << ppid_pkg::STEP_SAT_SH) : mul_prod;
    term_mag   = (mul_prod > (PW'(1) << ppid_pkg::TERM_SAT_SH)) ?
                 (PW'(1) << ppid_pkg::TERM_SAT_SH) : mul_prod;
    inc_mag_s  = INC_W'(step_mag);
    term_mag_s = TERM_W'(term_mag);
    b_mag_s    = B_W'(mul_prod);
  end

  // integral update and clamp to the scaled limit
  always_comb begin
    acc_sum = SUM_W'(acc_r) + SUM_W'(inc_r);
    ilim    = SUM_W'({cfg.integ_limit, {FRAC_BITS{1'b0}}});
    if (acc_sum > ilim) begin
      acc_nxt = AW'(ilim);
    end else if (acc_sum < -ilim) begin
      acc_nxt = AW'(-ilim);
    end else begin
      acc_nxt = AW'(acc_sum);
    end
  end

  // truncation toward zero and drive clamp
  always_comb begin
    t_fl  = T_W'(signed'(w_r[W_W-1:2*FRAC_BITS]));
    t_rnd = w_r[W_W-1] & (|w_r[2*FRAC_BITS-1:0]);
    t_val = t_fl + signed'({{(T_W-1){1'b0}}, t_rnd});
    lim   = T_W'(signed'({1'b0, cfg.drive_limit}));
    if (t_val > lim) begin
      drive_nxt = DRW'(lim);
    end else if (t_val < -lim) begin
      drive_nxt = DRW'(-lim);
    end else begin
      drive_nxt = DRW'(t_val);
    end
  end

  // step sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          op_nxt    = OP_INC;
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          unique case (op_r)
            OP_INC:   state_nxt = ST_ACC;
            OP_PROP: begin
              op_nxt    = OP_DERIV;
              state_nxt = ST_START;
            end
            OP_DERIV: begin
              op_nxt    = OP_INTEG;
              state_nxt = ST_START;
            end
            default:  state_nxt = ST_SUM1;
          endcase
        end
      end
      ST_ACC: begin
        op_nxt    = OP_PROP;
        state_nxt = ST_START;
      end
      ST_SUM1: state_nxt = ST_SUM2;
      ST_SUM2: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, integral and previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_INC;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_take) begin
        prev_r <= e_nxt;
      end
      if (state_r == ST_ACC) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      e_r <= e_nxt;
      d_r <= d_nxt;
    end
    if (mul_start) begin
      neg_r <= mul_neg;
    end
    if ((state_r == ST_WAIT) && mul_done) begin
      unique case (op_r)
        OP_INC:   inc_r <= neg_r ? -inc_mag_s : inc_mag_s;
        OP_PROP:  a_r   <= neg_r ? -term_mag_s : term_mag_s;
        OP_DERIV: c_r   <= neg_r ? -term_mag_s : term_mag_s;
        default:  b_r   <= neg_r ? -b_mag_s : b_mag_s;
      endcase
    end
    if (state_r == ST_SUM1) begin
      ac_r <= AC_W'(a_r) + AC_W'(c_r);
    end
    if (state_r == ST_SUM2) begin
      w_r <= (W_W'(ac_r) <<< FRAC_BITS) + W_W'(b_r);
    end
    if (out_load) begin
      out_drive_r <= drive_nxt;
    end
  end

endmodule

// ===== tb/sv/ppid_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppid_drive_checker - drive predictor and scoreboard for the PID controller
// Watches the register, request and result channels, keeps its own copy of
// the gains, limits, integral and last error, predicts the drive of every
// accepted request and compares each delivered drive with the oldest one due.
// ----------------------------------------------------------------------------
module ppid_drive_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [DATA_WIDTH-1:0]           in_target,
  input  logic signed [DATA_WIDTH-1:0]           in_measured,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [ppid_pkg::DRIVE_W-1:0]    out_drive,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ppid_pkg::CFG_DATA_W-1:0]        cfg_data,
  output int                                     fail_count,
  output int                                     drives_due
);

  localparam longint STEP_SAT = longint'(1) << ppid_pkg::STEP_SAT_SH;
  localparam longint TERM_SAT = longint'(1) << ppid_pkg::TERM_SAT_SH;
  localparam longint DRIVE_MAX = 32767;
  localparam longint DRIVE_MIN = -32768;

  // shadow register bank
  longint prop_k, integ_k, deriv_k, rate_k;
  longint integ_lim, drive_lim;
  // controller state
  longint integ_acc, last_err;

  logic signed [ppid_pkg::DRIVE_W-1:0] drive_q[$];

  function automatic longint clamp_sym(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // one control step: updates the integral and last error, returns the drive
  function automatic logic signed [ppid_pkg::DRIVE_W-1:0] pid_drive(
    input logic signed [DATA_WIDTH-1:0] tgt,
    input logic signed [DATA_WIDTH-1:0] meas
  );
    longint err, step, p_term, d_term;
    longint i_hi, i_lo, lo_prod, lo_q, lo_frac, i_term, sum, drv;
    err  = longint'(tgt) - longint'(meas);
    step = clamp_sym(err * rate_k, STEP_SAT);
    integ_acc = clamp_sym(integ_acc + step, integ_lim <<< FRAC_BITS);

    p_term = clamp_sym(prop_k * err, TERM_SAT);
    d_term = clamp_sym(deriv_k * (err - last_err), TERM_SAT);

    // integral term split into a whole part and the fraction below it
    i_hi    = integ_acc >>> FRAC_BITS;
    i_lo    = integ_acc - (i_hi <<< FRAC_BITS);
    lo_prod = integ_k * i_lo;
    lo_q    = lo_prod >>> FRAC_BITS;
    lo_frac = lo_prod - (lo_q <<< FRAC_BITS);
    i_term  = integ_k * i_hi + lo_q;

    // truncate toward zero, counting the dropped fraction
    sum = p_term + d_term + i_term;
    if (sum >= 0)
      drv = sum >>> FRAC_BITS;
    else if (lo_frac == 0)
      drv = -((-sum) >>> FRAC_BITS);
    else
      drv = -((-sum - 1) >>> FRAC_BITS);

    if (drv > DRIVE_MAX) drv = DRIVE_MAX;
    if (drv < DRIVE_MIN) drv = DRIVE_MIN;
    drv = clamp_sym(drv, drive_lim);

    last_err = err;
    return ppid_pkg::DRIVE_W'(drv);
  endfunction

  always @(posedge clk) begin
    logic signed [ppid_pkg::DRIVE_W-1:0] want;
    if (!rst_n) begin
      prop_k     = 0;
      integ_k    = 0;
      deriv_k    = 0;
      rate_k     = 0;
      integ_lim  = 0;
      drive_lim  = 0;
      integ_acc  = 0;
      last_err   = 0;
      drive_q.delete();
      fail_count <= 0;
      drives_due <= 0;
    end else begin
      // delivered drive against the oldest one due
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: drive %0d delivered with no request outstanding",
                   $time, out_drive);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_q.pop_front();
          if (out_drive !== want) begin
            $display("%0t: drive mismatch, expected %0d, got %0d",
                     $time, want, out_drive);
            fail_count <= fail_count + 1;
          end
        end
      end

      // accepted request
      if (in_valid && in_ready)
        drive_q.push_back(pid_drive(in_target, in_measured));

      // register write; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppid_pkg::REG_PROP_GAIN:   prop_k    = longint'($signed(cfg_data));
          ppid_pkg::REG_INTEG_GAIN:  integ_k   = longint'($signed(cfg_data));
          ppid_pkg::REG_DERIV_GAIN:  deriv_k   = longint'($signed(cfg_data));
          ppid_pkg::REG_INTEG_RATE:  rate_k    = longint'($signed(cfg_data));
          ppid_pkg::REG_INTEG_LIMIT:
            integ_lim = longint'(cfg_data[ppid_pkg::LIMIT_W-1:0]);
          ppid_pkg::REG_DRIVE_LIMIT:
            drive_lim = longint'(cfg_data[ppid_pkg::LIMIT_W-1:0]);
          default: ;
        endcase
      end

      drives_due <= drive_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_positional_pid_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_pid_controller - testbench top of the positional PID block
// Resets the block, loads gain and limit settings while it is idle, sends a
// short directed run and then random control steps under three idling
// patterns, and gives the verdict from the drive checker's failure and due counts.
// ----------------------------------------------------------------------------
module tb_positional_pid_controller;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  // cycles with no request moving on any channel before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES_PER_MODE = 4;
  localparam int STEPS_PER_PHASE = 84;
  // indexes outside the register bank
  localparam logic [ppid_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [ppid_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [DATA_WIDTH-1:0] EDGE_VALS [5] =
    '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   fail_count;
  int   drives_due;
  int   quiet_cycles = 0;

  ppid_in_if #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  ppid_out_if                           out_ch ();
  ppid_cfg_if                           cfg_ch ();

  positional_pid_controller #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  ppid_drive_checker #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) drive_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_target  (in_ch.target),
    .in_measured(in_ch.measured),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_drive  (out_ch.drive),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .fail_count (fail_count),
    .drives_due (drives_due)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on channel activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, now and then a long one to back the block up
  initial begin : drive_sink
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(199) == 0) begin
        hold = $urandom_range(30, 80);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one register write; valid stays up for a following write
  task automatic write_reg(input logic [ppid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppid_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_regs(input logic [31:0] kp, input logic [31:0] ki,
                           input logic [31:0] kd, input logic [31:0] rate,
                           input logic [31:0] ilim, input logic [31:0] dlim,
                           input bit spare);
    write_reg(ppid_pkg::REG_PROP_GAIN, kp);
    write_reg(ppid_pkg::REG_INTEG_GAIN, ki);
    write_reg(ppid_pkg::REG_DERIV_GAIN, kd);
    write_reg(ppid_pkg::REG_INTEG_RATE, rate);
    write_reg(ppid_pkg::REG_INTEG_LIMIT, ilim);
    write_reg(ppid_pkg::REG_DRIVE_LIMIT, dlim);
    if (spare) begin
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one control step request, after an optional idle gap
  task automatic send_step(input logic [DATA_WIDTH-1:0] tgt,
                           input logic [DATA_WIDTH-1:0] meas);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 60);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.target   <= tgt;
    in_ch.measured <= meas;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // lower the request and wait for every drive due
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drives_due != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9)) inside
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      [3:5]: return $urandom;
      default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(7)) inside
      0: return 32'd0;
      1: return 32'd32767;
      [2:3]: return $urandom;
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  initial begin : stimulus
    logic [DATA_WIDTH-1:0] tgt, meas;
    int delta;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.target   <= '0;
    in_ch.measured <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    send_idle_pct  <= 25;
    recv_idle_pct  <= 81;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: moderate gains, error extremes, integral into its clamp
    load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
              32'd100, 32'd32767, 1'b0);
    send_step(16'h0000, 16'h0000);
    send_step(16'h7FFF, 16'h8000);
    send_step(16'h8000, 16'h7FFF);
    send_step(16'h7FFF, 16'h7FFF);
    send_step(16'h8000, 16'h8000);
    repeat (4) send_step(16'd200, 16'd0);
    repeat (4) send_step(-16'sd200, 16'd0);
    send_step(16'd1, 16'd0);
    send_step(-16'sd1, 16'd0);
    drain();

    // directed: extreme gains, step saturation, int16 overflow
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF, 32'h7FFF, 1'b0);
    send_step(16'h7FFF, 16'h8000);
    send_step(16'h8000, 16'h7FFF);
    send_step(16'h0000, 16'h0000);
    send_step(16'd12345, -16'sd321);
    drain();

    // directed: zero limits, writes to unused indexes
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'hFFFF_8000, 32'd0, 1'b1);
    send_step(16'h8000, 16'h7FFF);
    send_step(16'h7FFF, 16'h8000);
    send_step(16'd500, -16'sd500);
    drain();

    // random: three idling patterns, several register settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct <= 25;
          recv_idle_pct <= 81;
        end
        1: begin
          send_idle_pct <= 81;
          recv_idle_pct <= 25;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        load_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  pick_limit(), pick_limit(), $urandom_range(3) == 0);
        for (int n = 0; n < STEPS_PER_PHASE; n++) begin
          case ($urandom_range(19)) inside
            [0:2]: begin
              tgt  = EDGE_VALS[$urandom_range(4)];
              meas = EDGE_VALS[$urandom_range(4)];
            end
            [3:7]: begin
              tgt  = DATA_WIDTH'($urandom);
              meas = DATA_WIDTH'($urandom);
            end
            default: begin
              // tracking loop: measurement close to the setpoint
              delta = int'($urandom_range(600)) - 300;
              tgt   = DATA_WIDTH'($urandom);
              meas  = tgt + DATA_WIDTH'(delta);
            end
          endcase
          send_step(tgt, meas);
        end
        drain();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && drives_due == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
